// ===== design/circle_segment_collision_resolve_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the circle/segment collision resolve core
// Concurrent assertion wrappers; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_SEGMENT_COLLISION_RESOLVE_CORE_MACROS_SVH
`define CIRCLE_SEGMENT_COLLISION_RESOLVE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define CSCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define CSCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CSCR_ASSERT(lbl, prop, msg)
`define CSCR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/cscr_pkg.sv =====
// ----------------------------------------------------------------------------
// cscr_pkg
// Shared types, constants and helpers of the collision resolve core.
// ----------------------------------------------------------------------------
package cscr_pkg;

  localparam int unsigned MaxSegmentsDefault = 32;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic OpLoad    = 1'b0;
  localparam logic OpResolve = 1'b1;

  localparam int unsigned DivNumW = 52;
  localparam int unsigned DivDenW = 34;
  localparam int unsigned DivQuoW = 18;

  typedef enum logic [1:0] {
    RegRadius = 2'd0,
    RegRefl   = 2'd1,
    RegCount  = 2'd2
  } reg_idx_e;

  typedef enum logic [5:0] {
    OP_NONE, OP_INIT, OP_R2, OP_LATCH, OP_DEN0, OP_DEN1, OP_NUM0, OP_NUM1,
    OP_TSEL, OP_TGET, OP_CSTART, OP_CX0, OP_CX1, OP_CY, OP_DIFF, OP_D2A,
    OP_D2B, OP_SQS, OP_LGET, OP_PXM, OP_PXD, OP_PXG, OP_PYM, OP_PYD, OP_PYG,
    OP_VD0, OP_VD1, OP_RXM, OP_RXD, OP_RXG, OP_RYM, OP_RYD, OP_RYG,
    OP_SXM, OP_SXG, OP_SYM, OP_SYG
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_R2, ST_CHK, ST_RD, ST_LATCH, ST_DEN0, ST_DEN1, ST_NUM0,
    ST_NUM1, ST_TSEL, ST_TWAIT, ST_TGET, ST_CSTART, ST_CX0, ST_CX1, ST_CY,
    ST_DIFF, ST_D2A, ST_D2B, ST_HIT, ST_SQS, ST_SQW, ST_LGET, ST_PXM, ST_PXD,
    ST_PXW, ST_PXG, ST_PYM, ST_PYD, ST_PYW, ST_PYG, ST_VD0, ST_VD1, ST_RXM,
    ST_RXD, ST_RXW, ST_RXG, ST_RYM, ST_RYD, ST_RYW, ST_RYG, ST_SXM, ST_SXG,
    ST_SYM, ST_SYG, ST_NEXT, ST_DONE
  } state_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic num_le0;
    logic num_ge;
    logic hit;
    logic div_idle;
    logic sqrt_idle;
  } dp_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [52:0] v);
    if (v > 53'sd32767) return 16'sh7fff;
    if (v < -53'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // round to nearest, halves away from zero, then shift right
  function automatic logic signed [52:0] rnd_shr(input logic signed [52:0] v,
                                                input int unsigned sh);
    logic [52:0] mag;
    logic [52:0] half;
    mag  = v[52] ? 53'(-v) : 53'(v);
    half = 53'(1) << (sh - 1);
    mag  = (mag + half) >> sh;
    return v[52] ? -signed'(mag) : signed'(mag);
  endfunction

endpackage

// ===== design/cscr_ram.sv =====
// ----------------------------------------------------------------------------
// cscr_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module cscr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cscr_div.sv =====
// ----------------------------------------------------------------------------
// cscr_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cscr_div #(
  parameter int unsigned NumW = 52,
  parameter int unsigned DenW = 34,
  parameter int unsigned QuoW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            idle_o,
  output logic [QuoW-1:0] quo_o
);

  localparam int unsigned CntW = (QuoW > 1) ? $clog2(QuoW) : 1;

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [QuoW-1:0] sh_q;
  logic [DenW:0]   trial;
  logic            ge;

  // caller guarantees num < den * 2^QuoW, so the top part starts below den
  assign trial = {rem_q, sh_q[QuoW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(QuoW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DenW'(num_i >> QuoW);
      sh_q  <= num_i[QuoW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      sh_q  <= {sh_q[QuoW-2:0], ge};
    end
  end

  assign idle_o = !busy_q;
  assign quo_o  = sh_q;

endmodule

// ===== design/cscr_dp.sv =====
// ----------------------------------------------------------------------------
// cscr_dp
// Datapath: shared multiplier, divider and square root unit, per-segment
// geometry registers and the running ball state.
// ----------------------------------------------------------------------------
module cscr_dp import cscr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic signed [15:0] ball_x_i,
  input  logic signed [15:0] ball_y_i,
  input  logic signed [15:0] speed_x_i,
  input  logic signed [15:0] speed_y_i,
  input  logic [14:0]        radius_i,
  input  logic [15:0]        refl_i,
  input  logic [63:0]        seg_i,
  output logic signed [15:0] ball_x_o,
  output logic signed [15:0] ball_y_o,
  output logic signed [15:0] speed_x_o,
  output logic signed [15:0] speed_y_o
);

  logic signed [15:0] ax_q, ay_q, px_q, py_q, vx_q, vy_q;
  logic signed [16:0] abx_q, aby_q, apx_q, apy_q, cx_q, cy_q;
  logic signed [17:0] dx_q, dy_q;
  logic [33:0]        den_q;
  logic signed [34:0] num_q, vd_q;
  logic [16:0]        t_q;
  logic [35:0]        dist2_q;
  logic [29:0]        r2_q;
  logic [23:0]        len_q;
  logic signed [19:0] rx_q, ry_q;
  logic signed [52:0] prod_q;
  logic               div_neg_q;

  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [52:0] mul_p, mac;
  logic [52:0]        prod_mag;

  logic               div_start, div_neg, div_idle;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic [DivQuoW-1:0] div_quo;
  logic signed [DivQuoW:0] q_s;

  logic        sq_busy_q;
  logic [4:0]  sq_cnt_q;
  logic [24:0] sq_rem_q;
  logic [23:0] sq_root_q;
  logic [47:0] sq_in_q;
  logic [26:0] sq_rsh, sq_trial;
  logic        sq_ge;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_R2:   begin
        mul_a = 35'(signed'({1'b0, radius_i}));
        mul_b = 18'(signed'({1'b0, radius_i}));
      end
      OP_DEN0: begin mul_a = 35'(abx_q); mul_b = 18'(abx_q); end
      OP_DEN1: begin mul_a = 35'(aby_q); mul_b = 18'(aby_q); end
      OP_NUM0: begin mul_a = 35'(apx_q); mul_b = 18'(abx_q); end
      OP_NUM1: begin mul_a = 35'(apy_q); mul_b = 18'(aby_q); end
      OP_CX0:  begin mul_a = 35'(signed'({1'b0, t_q})); mul_b = 18'(abx_q); end
      OP_CX1:  begin mul_a = 35'(signed'({1'b0, t_q})); mul_b = 18'(aby_q); end
      OP_D2A:  begin mul_a = 35'(dx_q); mul_b = dx_q; end
      OP_D2B:  begin mul_a = 35'(dy_q); mul_b = dy_q; end
      OP_PXM:  begin mul_a = 35'(dx_q); mul_b = 18'(signed'({1'b0, radius_i})); end
      OP_PYM:  begin mul_a = 35'(dy_q); mul_b = 18'(signed'({1'b0, radius_i})); end
      OP_VD0:  begin mul_a = 35'(vx_q); mul_b = dx_q; end
      OP_VD1:  begin mul_a = 35'(vy_q); mul_b = dy_q; end
      OP_RXM:  begin mul_a = vd_q; mul_b = dx_q; end
      OP_RYM:  begin mul_a = vd_q; mul_b = dy_q; end
      OP_SXM:  begin mul_a = 35'(rx_q); mul_b = 18'(signed'({1'b0, refl_i})); end
      OP_SYM:  begin mul_a = 35'(ry_q); mul_b = 18'(signed'({1'b0, refl_i})); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p    = 53'(mul_a) * 53'(mul_b);
  assign mac      = prod_q + mul_p;
  assign prod_mag = prod_q[52] ? 53'(-prod_q) : 53'(prod_q);

  // divider operands; for the projection and reflection divisions the rounding half is folded into the dividend
  always_comb begin
    div_start = 1'b0;
    div_neg   = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd_i.op)
      OP_TSEL: begin
        div_start = !status_o.num_le0 && !status_o.num_ge;
        div_num   = {2'b00, num_q[33:0], 16'h0000};
        div_den   = den_q;
      end
      OP_PXD, OP_PYD: begin
        div_start = 1'b1;
        div_neg   = prod_q[52];
        div_num   = DivNumW'((prod_mag << 8) + 53'(len_q >> 1));
        div_den   = DivDenW'(len_q);
      end
      OP_RXD, OP_RYD: begin
        div_start = 1'b1;
        div_neg   = prod_q[52];
        div_num   = DivNumW'((prod_mag << 1) + 53'(dist2_q[35:1]));
        div_den   = dist2_q[33:0];
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  cscr_div #(
    .NumW(DivNumW),
    .DenW(DivDenW),
    .QuoW(DivQuoW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .idle_o (div_idle),
    .quo_o  (div_quo)
  );

  assign q_s = div_neg_q ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});

  // integer square root, two radicand bits per cycle
  assign sq_rsh   = {sq_rem_q, sq_in_q[47:46]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};
  assign sq_ge    = sq_rsh >= sq_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else if (cmd_i.op == OP_SQS) begin
      sq_busy_q <= 1'b1;
      sq_cnt_q  <= '0;
    end else if (sq_busy_q) begin
      sq_cnt_q <= sq_cnt_q + 5'd1;
      if (sq_cnt_q == 5'd23) begin
        sq_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SQS) begin
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_in_q   <= {2'b00, dist2_q[29:0], 16'h0000};
    end else if (sq_busy_q) begin
      sq_rem_q  <= sq_ge ? 25'(sq_rsh - sq_trial) : 25'(sq_rsh);
      sq_root_q <= {sq_root_q[22:0], sq_ge};
      sq_in_q   <= {sq_in_q[45:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_neg_q <= div_neg;
    end
    unique case (cmd_i.op)
      OP_INIT: begin
        px_q <= ball_x_i;
        py_q <= ball_y_i;
        vx_q <= speed_x_i;
        vy_q <= speed_y_i;
      end
      OP_R2:    r2_q <= 30'(mul_p);
      OP_LATCH: begin
        ax_q  <= seg_i[63:48];
        ay_q  <= seg_i[47:32];
        abx_q <= 17'(signed'(seg_i[31:16])) - 17'(signed'(seg_i[63:48]));
        aby_q <= 17'(signed'(seg_i[15:0])) - 17'(signed'(seg_i[47:32]));
        apx_q <= 17'(px_q) - 17'(signed'(seg_i[63:48]));
        apy_q <= 17'(py_q) - 17'(signed'(seg_i[47:32]));
      end
      OP_DEN0, OP_NUM0, OP_CX0, OP_D2A, OP_PXM, OP_PYM, OP_VD0, OP_RXM,
      OP_RYM, OP_SXM, OP_SYM: prod_q <= mul_p;
      OP_DEN1:  den_q <= 34'(mac);
      OP_NUM1:  num_q <= 35'(mac);
      OP_TSEL: begin
        // clamped ends; the interior case arrives through the divider
        t_q <= status_o.num_le0 ? 17'd0 : 17'h10000;
      end
      OP_TGET:  t_q <= 17'(div_quo);
      OP_CSTART: begin
        cx_q <= 17'(ax_q);
        cy_q <= 17'(ay_q);
      end
      OP_CX1: begin
        cx_q   <= 17'(53'(ax_q) + rnd_shr(prod_q, 16));
        prod_q <= mul_p;
      end
      OP_CY:    cy_q <= 17'(53'(ay_q) + rnd_shr(prod_q, 16));
      OP_DIFF: begin
        dx_q <= 18'(px_q) - 18'(cx_q);
        dy_q <= 18'(py_q) - 18'(cy_q);
      end
      OP_D2B:   dist2_q <= 36'(mac);
      OP_LGET:  len_q <= sq_root_q;
      OP_PXG:   px_q <= sat16(53'(cx_q) + 53'(q_s));
      OP_PYG:   py_q <= sat16(53'(cy_q) + 53'(q_s));
      OP_VD1:   vd_q <= 35'(mac);
      OP_RXG:   rx_q <= 20'(vx_q) - 20'(q_s);
      OP_RYG:   ry_q <= 20'(vy_q) - 20'(q_s);
      OP_SXG:   vx_q <= sat16(rnd_shr(prod_q, 15));
      OP_SYG:   vy_q <= sat16(rnd_shr(prod_q, 15));
      default: begin
      end
    endcase
  end

  assign status_o.den_zero  = den_q == '0;
  assign status_o.num_le0   = num_q <= 35'sd0;
  assign status_o.num_ge    = num_q >= signed'({1'b0, den_q});
  assign status_o.hit       = (dist2_q <= 36'(r2_q)) && (dist2_q != '0);
  assign status_o.div_idle  = div_idle;
  assign status_o.sqrt_idle = !sq_busy_q;

  assign ball_x_o  = px_q;
  assign ball_y_o  = py_q;
  assign speed_x_o = vx_q;
  assign speed_y_o = vy_q;

endmodule

// ===== design/cscr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cscr_ctrl
// Sequencer: walks the segment table and issues datapath micro-ops.
// ----------------------------------------------------------------------------
`include "circle_segment_collision_resolve_core_macros.svh"

module cscr_ctrl import cscr_pkg::*; #(
  parameter int unsigned MaxSegments = MaxSegmentsDefault,
  localparam int unsigned AddrW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1,
  localparam int unsigned IdxW  = $clog2(MaxSegments + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             operation_i,
  input  logic [5:0]       seg_count_i,
  input  dp_status_t       status_i,
  output dp_cmd_t          cmd_o,
  output logic             busy_o,
  output logic             done_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o
);

  state_e         state_q, state_d;
  logic [IdxW-1:0] idx_q;
  logic [8:0]      cnt_w;
  logic [IdxW-1:0] cnt_eff;
  logic            accept;

  assign cnt_w   = 9'(seg_count_i);
  assign cnt_eff = (cnt_w > 9'(MaxSegments)) ? IdxW'(MaxSegments) : IdxW'(cnt_w);
  assign accept  = start_i && (state_q == ST_IDLE) && (operation_i == OpResolve);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_R2;
      ST_R2:     state_d = ST_CHK;
      ST_CHK:    state_d = (idx_q < cnt_eff) ? ST_RD : ST_DONE;
      ST_RD:     state_d = ST_LATCH;
      ST_LATCH:  state_d = ST_DEN0;
      ST_DEN0:   state_d = ST_DEN1;
      ST_DEN1:   state_d = ST_NUM0;
      ST_NUM0:   state_d = ST_NUM1;
      ST_NUM1:   state_d = ST_TSEL;
      ST_TSEL: begin
        priority if (status_i.den_zero) state_d = ST_CSTART;
        else if (status_i.num_le0 || status_i.num_ge) state_d = ST_CX0;
        else state_d = ST_TWAIT;
      end
      ST_TWAIT:  if (status_i.div_idle) state_d = ST_TGET;
      ST_TGET:   state_d = ST_CX0;
      ST_CSTART: state_d = ST_DIFF;
      ST_CX0:    state_d = ST_CX1;
      ST_CX1:    state_d = ST_CY;
      ST_CY:     state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_D2A;
      ST_D2A:    state_d = ST_D2B;
      ST_D2B:    state_d = ST_HIT;
      ST_HIT:    state_d = status_i.hit ? ST_SQS : ST_NEXT;
      ST_SQS:    state_d = ST_SQW;
      ST_SQW:    if (status_i.sqrt_idle) state_d = ST_LGET;
      ST_LGET:   state_d = ST_PXM;
      ST_PXM:    state_d = ST_PXD;
      ST_PXD:    state_d = ST_PXW;
      ST_PXW:    if (status_i.div_idle) state_d = ST_PXG;
      ST_PXG:    state_d = ST_PYM;
      ST_PYM:    state_d = ST_PYD;
      ST_PYD:    state_d = ST_PYW;
      ST_PYW:    if (status_i.div_idle) state_d = ST_PYG;
      ST_PYG:    state_d = ST_VD0;
      ST_VD0:    state_d = ST_VD1;
      ST_VD1:    state_d = ST_RXM;
      ST_RXM:    state_d = ST_RXD;
      ST_RXD:    state_d = ST_RXW;
      ST_RXW:    if (status_i.div_idle) state_d = ST_RXG;
      ST_RXG:    state_d = ST_RYM;
      ST_RYM:    state_d = ST_RYD;
      ST_RYD:    state_d = ST_RYW;
      ST_RYW:    if (status_i.div_idle) state_d = ST_RYG;
      ST_RYG:    state_d = ST_SXM;
      ST_SXM:    state_d = ST_SXG;
      ST_SXG:    state_d = ST_SYM;
      ST_SYM:    state_d = ST_SYG;
      ST_SYG:    state_d = ST_NEXT;
      ST_NEXT:   state_d = ST_CHK;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      ST_IDLE:   cmd_o.op = accept ? OP_INIT : OP_NONE;
      ST_R2:     cmd_o.op = OP_R2;
      ST_LATCH:  cmd_o.op = OP_LATCH;
      ST_DEN0:   cmd_o.op = OP_DEN0;
      ST_DEN1:   cmd_o.op = OP_DEN1;
      ST_NUM0:   cmd_o.op = OP_NUM0;
      ST_NUM1:   cmd_o.op = OP_NUM1;
      ST_TSEL:   cmd_o.op = status_i.den_zero ? OP_NONE : OP_TSEL;
      ST_TGET:   cmd_o.op = OP_TGET;
      ST_CSTART: cmd_o.op = OP_CSTART;
      ST_CX0:    cmd_o.op = OP_CX0;
      ST_CX1:    cmd_o.op = OP_CX1;
      ST_CY:     cmd_o.op = OP_CY;
      ST_DIFF:   cmd_o.op = OP_DIFF;
      ST_D2A:    cmd_o.op = OP_D2A;
      ST_D2B:    cmd_o.op = OP_D2B;
      ST_SQS:    cmd_o.op = OP_SQS;
      ST_LGET:   cmd_o.op = OP_LGET;
      ST_PXM:    cmd_o.op = OP_PXM;
      ST_PXD:    cmd_o.op = OP_PXD;
      ST_PXG:    cmd_o.op = OP_PXG;
      ST_PYM:    cmd_o.op = OP_PYM;
      ST_PYD:    cmd_o.op = OP_PYD;
      ST_PYG:    cmd_o.op = OP_PYG;
      ST_VD0:    cmd_o.op = OP_VD0;
      ST_VD1:    cmd_o.op = OP_VD1;
      ST_RXM:    cmd_o.op = OP_RXM;
      ST_RXD:    cmd_o.op = OP_RXD;
      ST_RXG:    cmd_o.op = OP_RXG;
      ST_RYM:    cmd_o.op = OP_RYM;
      ST_RYD:    cmd_o.op = OP_RYD;
      ST_RYG:    cmd_o.op = OP_RYG;
      ST_SXM:    cmd_o.op = OP_SXM;
      ST_SXG:    cmd_o.op = OP_SXG;
      ST_SYM:    cmd_o.op = OP_SYM;
      ST_SYG:    cmd_o.op = OP_SYG;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        idx_q <= '0;
      end else if (state_q == ST_NEXT) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  assign busy_o    = state_q != ST_IDLE;
  assign done_o    = state_q == ST_DONE;
  assign rd_en_o   = state_q == ST_RD;
  assign rd_addr_o = AddrW'(idx_q);

  `CSCR_ASSERT(a_done_single, done_o |=> !done_o, "result strobe held past one cycle")
  `CSCR_ASSERT(a_div_launched, (state_q == ST_PXD || state_q == ST_RXD) |=> !status_i.div_idle, "divider not started")
  `CSCR_ASSERT(a_idx_range, idx_q <= IdxW'(MaxSegments), "segment index past table")

endmodule

// ===== design/circle_segment_collision_resolve_core.sv =====
// ----------------------------------------------------------------------------
// circle_segment_collision_resolve_core
// Resolves a ball against a table of wall segments, fixed point Q3.12.
// ----------------------------------------------------------------------------
// A load request (operation 0) writes one segment into the table in the cycle
// it is accepted and leaves busy low. A resolve request (operation 1) raises
// busy and walks segments 0 .. min(segments_in_use, MAX_SEGMENTS)-1 on one
// shared multiplier, a radix-2 divider and a 2-bit per cycle square root.
// A segment the ball misses takes the zero-length path, the path with the
// projection clamped to an end, or the path with the projection inside the
// segment and one division; a hit adds one square root and four divisions in
// series. The result shows on the new_* ports for the single cycle done_o is
// high and must be taken then; busy drops in the next cycle.
module circle_segment_collision_resolve_core import cscr_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                operation_i,
  input  logic [4:0]          segment_slot_i,
  input  logic signed [15:0]  start_x_i,
  input  logic signed [15:0]  start_y_i,
  input  logic signed [15:0]  end_x_i,
  input  logic signed [15:0]  end_y_i,
  input  logic signed [15:0]  ball_x_i,
  input  logic signed [15:0]  ball_y_i,
  input  logic signed [15:0]  speed_x_i,
  input  logic signed [15:0]  speed_y_i,
  output logic                done_o,
  output logic signed [15:0]  new_ball_x_o,
  output logic signed [15:0]  new_ball_y_o,
  output logic signed [15:0]  new_speed_x_o,
  output logic signed [15:0]  new_speed_y_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned AddrW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  logic [14:0] radius_q;
  logic [15:0] refl_q;
  logic [5:0]  count_q;
  logic        cfg_we;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [63:0]      ram_rdata;
  dp_cmd_t          cmd;
  dp_status_t       status;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      refl_q   <= 16'h8000;
      count_q  <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        RegRadius: radius_q <= pwdata[14:0];
        RegRefl:   refl_q   <= pwdata[15:0];
        RegCount:  count_q  <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegRadius: prdata = ApbDataW'(radius_q);
      RegRefl:   prdata = ApbDataW'(refl_q);
      RegCount:  prdata = ApbDataW'(count_q);
      default:   prdata = '0;
    endcase
  end

  // loads go straight to the table; slots past the table are dropped
  assign ram_we = start && !busy && (operation_i == OpLoad) &&
                  (9'(segment_slot_i) < 9'(MAX_SEGMENTS));

  cscr_ram #(
    .Width(64),
    .Depth(MAX_SEGMENTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AddrW'(segment_slot_i)),
    .wdata_i({start_x_i, start_y_i, end_x_i, end_y_i}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cscr_ctrl #(
    .MaxSegments(MAX_SEGMENTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .operation_i(operation_i),
    .seg_count_i(count_q),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .done_o     (done_o),
    .rd_en_o    (ram_re),
    .rd_addr_o  (ram_raddr)
  );

  cscr_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .ball_x_i (ball_x_i),
    .ball_y_i (ball_y_i),
    .speed_x_i(speed_x_i),
    .speed_y_i(speed_y_i),
    .radius_i (radius_q),
    .refl_i   (refl_q),
    .seg_i    (ram_rdata),
    .ball_x_o (new_ball_x_o),
    .ball_y_o (new_ball_y_o),
    .speed_x_o(new_speed_x_o),
    .speed_y_o(new_speed_y_o)
  );

endmodule

// ===== bench/circle_segment_collision_resolve_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_segment_collision_resolve_core_tb
// Loads wall segments and resolves balls against them, checking every
// resolved position and velocity against a fixed-point predictor of the core.
// ----------------------------------------------------------------------------
module circle_segment_collision_resolve_core_tb import cscr_pkg::*;;

  localparam int unsigned NumSlots   = 32;
  localparam longint      CycleLimit = 40000000;

  typedef struct {
    logic               op;
    logic [4:0]         slot;
    logic signed [15:0] sx, sy, ex, ey;
    logic signed [15:0] bx, by, vx, vy;
  } request_t;

  typedef struct {
    logic signed [15:0] px, py, vx, vy;
  } ball_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic operation_i = OpLoad;
  logic [4:0] segment_slot_i = '0;
  logic signed [15:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic signed [15:0] ball_x_i = '0, ball_y_i = '0, speed_x_i = '0, speed_y_i = '0;
  logic done_o;
  logic signed [15:0] new_ball_x_o, new_ball_y_o, new_speed_x_o, new_speed_y_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  circle_segment_collision_resolve_core u_dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  longint wall_sx[NumSlots], wall_sy[NumSlots], wall_ex[NumSlots], wall_ey[NumSlots];
  longint cfg_radius = 0, cfg_refl = 32768, cfg_count = 0;

  request_t    pending_requests[$];
  ball_state_t expected_balls[$];
  request_t    cur_req;
  int          sender_idle_pct = 0;
  int          mismatches = 0;
  longint      cycles = 0;

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint sat_q12(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic ball_state_t resolve_ball(request_t rq);
    longint px, py, vx, vy, r, n, ax, ay, abx, aby, num, den, cx, cy, t;
    longint dx, dy, dist2, len, vd, rx, ry;
    ball_state_t res;
    px = longint'(rq.bx); py = longint'(rq.by);
    vx = longint'(rq.vx); vy = longint'(rq.vy);
    r = cfg_radius;
    n = (cfg_count > longint'(NumSlots)) ? longint'(NumSlots) : cfg_count;
    for (int i = 0; i < n; i++) begin
      ax = wall_sx[i]; ay = wall_sy[i];
      abx = wall_ex[i] - ax; aby = wall_ey[i] - ay;
      num = (px - ax) * abx + (py - ay) * aby;
      den = abx * abx + aby * aby;
      cx = ax; cy = ay;
      if (den != 0) begin
        if (num <= 0) t = 0;
        else if (num >= den) t = 65536;
        else t = (num << 16) / den;
        cx = ax + round_div(t * abx, 65536);
        cy = ay + round_div(t * aby, 65536);
      end
      dx = px - cx; dy = py - cy;
      dist2 = dx * dx + dy * dy;
      if (dist2 > r * r || dist2 == 0) continue;
      len = int_sqrt(longint'(dist2) << 16);
      px = sat_q12(cx + round_div(dx * r * 256, len));
      py = sat_q12(cy + round_div(dy * r * 256, len));
      vd = vx * dx + vy * dy;
      rx = vx - round_div(2 * vd * dx, dist2);
      ry = vy - round_div(2 * vd * dy, dist2);
      vx = sat_q12(round_div(rx * cfg_refl, 32768));
      vy = sat_q12(round_div(ry * cfg_refl, 32768));
    end
    res.px = px[15:0]; res.py = py[15:0]; res.vx = vx[15:0]; res.vy = vy[15:0];
    return res;
  endfunction

  // request driver: start stays high until the core takes the request
  always @(posedge clk_i) begin
    logic accepted, next_start;
    accepted   = start && !busy;
    next_start = start && !accepted;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (accepted) begin
        if (cur_req.op == OpLoad) begin
          wall_sx[cur_req.slot] = longint'(cur_req.sx);
          wall_sy[cur_req.slot] = longint'(cur_req.sy);
          wall_ex[cur_req.slot] = longint'(cur_req.ex);
          wall_ey[cur_req.slot] = longint'(cur_req.ey);
        end else begin
          expected_balls.push_back(resolve_ball(cur_req));
        end
      end
      if (!next_start && pending_requests.size() > 0 &&
          int'($urandom_range(99)) >= sender_idle_pct) begin
        cur_req = pending_requests.pop_front();
        operation_i    <= cur_req.op;
        segment_slot_i <= cur_req.slot;
        start_x_i <= cur_req.sx; start_y_i <= cur_req.sy;
        end_x_i   <= cur_req.ex; end_y_i   <= cur_req.ey;
        ball_x_i  <= cur_req.bx; ball_y_i  <= cur_req.by;
        speed_x_i <= cur_req.vx; speed_y_i <= cur_req.vy;
        next_start = 1'b1;
      end
      start <= next_start;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    ball_state_t exp_b;
    if (rst_ni && done_o) begin
      if (expected_balls.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0d %0d",
            new_ball_x_o, new_ball_y_o, new_speed_x_o, new_speed_y_o);
      end else begin
        exp_b = expected_balls.pop_front();
        if (exp_b.px !== new_ball_x_o || exp_b.py !== new_ball_y_o ||
            exp_b.vx !== new_speed_x_o || exp_b.vy !== new_speed_y_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ball (%0d,%0d) speed (%0d,%0d), got (%0d,%0d) (%0d,%0d)",
                exp_b.px, exp_b.py, exp_b.vx, exp_b.vy,
                new_ball_x_o, new_ball_y_o, new_speed_x_o, new_speed_y_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("circle_segment_collision_resolve_core_tb: done, errors");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_e idx, longint value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ApbAddrW'(idx) << 2; pwdata <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegRadius: cfg_radius = value & 64'h7fff;
      RegRefl:   cfg_refl   = value & 64'hffff;
      default:   cfg_count  = value & 64'h3f;
    endcase
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && expected_balls.size() == 0 && !start);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic setup(longint radius, longint refl, longint count);
    drain();
    reg_write(RegRadius, radius);
    reg_write(RegRefl, refl);
    reg_write(RegCount, count);
  endtask

  function automatic request_t rand_request(logic op);
    request_t rq;
    rq.op = op; rq.slot = 5'($urandom);
    rq.sx = 16'($urandom); rq.sy = 16'($urandom);
    rq.ex = 16'($urandom); rq.ey = 16'($urandom);
    rq.bx = 16'($urandom); rq.by = 16'($urandom);
    rq.vx = 16'($urandom); rq.vy = 16'($urandom);
    return rq;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    return 16'(sat_q12(v));
  endfunction

  // ball near a loaded wall, inside or just outside the radius
  function automatic request_t near_ball();
    request_t rq;
    longint i, t, reach;
    rq = rand_request(OpResolve);
    i = (cfg_count == 0) ? 0 : longint'($urandom_range(32'(((cfg_count >
        longint'(NumSlots)) ? longint'(NumSlots) : cfg_count) - 1)));
    t = longint'($urandom_range(1024));
    reach = cfg_radius + 64;
    rq.bx = clip16(wall_sx[i] + ((wall_ex[i] - wall_sx[i]) * t) / 1024 +
                   longint'($urandom_range(32'(2 * reach))) - reach);
    rq.by = clip16(wall_sy[i] + ((wall_ey[i] - wall_sy[i]) * t) / 1024 +
                   longint'($urandom_range(32'(2 * reach))) - reach);
    if ($urandom_range(3) == 0) begin
      rq.vx = clip16(longint'($urandom_range(4000)) - 2000);
      rq.vy = clip16(longint'($urandom_range(4000)) - 2000);
    end
    return rq;
  endfunction

  function automatic request_t load_req(int slot, longint sx, longint sy,
                                        longint ex, longint ey);
    request_t rq;
    rq = rand_request(OpLoad);
    rq.slot = 5'(slot); rq.sx = 16'(sx); rq.sy = 16'(sy);
    rq.ex = 16'(ex); rq.ey = 16'(ey);
    return rq;
  endfunction

  function automatic request_t ball_req(longint bx, longint by, longint vx, longint vy);
    request_t rq;
    rq = rand_request(OpResolve);
    rq.bx = 16'(bx); rq.by = 16'(by); rq.vx = 16'(vx); rq.vy = 16'(vy);
    return rq;
  endfunction

  initial begin
    int idle_plan[4];
    longint radius, refl, count;
    int n_items;
    idle_plan = '{0, 54, 0, 22};
    for (int i = 0; i < NumSlots; i++) begin
      wall_sx[i] = 0; wall_sy[i] = 0; wall_ex[i] = 0; wall_ey[i] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: a ball resolved against no walls with count 0, then special walls
    pending_requests.push_back(ball_req(-32768, 32767, 32767, -32768));
    pending_requests.push_back(load_req(0, 4096, 4096, 4096, 4096));     // zero length
    pending_requests.push_back(load_req(1, -8192, 0, 8192, 0));
    pending_requests.push_back(load_req(2, 0, -8192, 0, 8192));
    pending_requests.push_back(load_req(3, -32768, -32768, 32767, 32767));
    pending_requests.push_back(load_req(4, 32767, -32768, -32768, 32767));
    pending_requests.push_back(load_req(31, 100, 200, 300, 400));
    setup(2048, 32768, 5);
    pending_requests.push_back(ball_req(4096, 4096, 1000, 1000));   // on zero-length wall
    pending_requests.push_back(ball_req(5000, 4500, -3000, 700));   // near wall start point
    pending_requests.push_back(ball_req(0, 0, 100, 100));           // centre on a wall
    pending_requests.push_back(ball_req(1000, 1000, 32767, -32768));
    pending_requests.push_back(ball_req(-9000, 500, 4000, -4000));  // beyond wall end
    pending_requests.push_back(ball_req(32767, 32767, -32768, 32767));
    setup(32767, 65535, 5);                                         // speeds saturate
    pending_requests.push_back(ball_req(1200, -800, 20000, -15000));
    pending_requests.push_back(ball_req(-32768, -32768, 32767, 32767));
    setup(4000, 0, 63);                                             // count past table
    for (int i = 5; i < NumSlots; i++)
      pending_requests.push_back(load_req(i, longint'($urandom), longint'($urandom),
                                          longint'($urandom), longint'($urandom)));
    drain();
    pending_requests.push_back(ball_req(300, 500, 1234, -4321));

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0:       radius = longint'($urandom_range(8192));
        1:       radius = longint'($urandom_range(32767));
        2:       radius = (ph == 2) ? 0 : 32767;
        default: radius = longint'($urandom_range(2048));
      endcase
      case (ph % 3)
        0:       refl = longint'($urandom_range(32768));
        1:       refl = 32768;
        default: refl = (ph == 5) ? 0 : longint'($urandom_range(65535));
      endcase
      count = (ph == 7) ? 32 : (ph == 10) ? 40 : longint'($urandom_range(6, 1));
      setup(radius, refl, count);
      sender_idle_pct = idle_plan[ph % 4];
      n_items = (count > 8) ? 30 : 90;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(99) < 12) pending_requests.push_back(rand_request(OpLoad));
        else if ($urandom_range(99) < 15)
          pending_requests.push_back(rand_request(OpResolve));
        else pending_requests.push_back(near_ball());
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_balls.size() == 0) begin
      $display("circle_segment_collision_resolve_core_tb: done, clean");
    end else begin
      $display("circle_segment_collision_resolve_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/cscr_pkg.sv
design/cscr_ram.sv
design/cscr_div.sv
design/cscr_dp.sv
design/cscr_ctrl.sv
design/circle_segment_collision_resolve_core.sv
bench/circle_segment_collision_resolve_core_tb.sv
